// ===== src/mcdt_pkg.sv =====
// Shared types, codes and constants for the deadline timer table.
package mcdt_pkg;

	// Number of timer slots; handles and indexes are 4 bits wide.
	localparam int NUM_TIMERS = 16;
	// Most expiry results one tick may report.
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	// Query answer when no slot is armed.
	localparam logic [31:0] NONE_ARMED = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_CREATE     = 3'd0,
		OP_START      = 3'd1,
		OP_STOP       = 3'd2,
		OP_SET_PERIOD = 3'd3,
		OP_DELETE     = 3'd4,
		OP_TICK       = 3'd5,
		OP_QUERY      = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACK     = 3'd0,
		KIND_CREATED = 3'd1,
		KIND_EXPIRED = 3'd2,
		KIND_NEXT    = 3'd3,
		KIND_NONE    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_START_WR,
		ST_CREATE,
		ST_TICK,
		ST_QUERY,
		ST_RESP
	} state_t;

	// Controller -> datapath commands.
	typedef struct packed {
		logic load_in;
		logic idx_clr;
		logic idx_inc;
		logic rd_handle;
		logic stage_ack;
		logic do_start;
		logic do_stop;
		logic do_set_period;
		logic do_delete;
		logic create_claim;
		logic create_fail;
		logic tick_init;
		logic tick_hit;
		logic query_init;
		logic query_step;
		logic push_last;
	} ctl_cmd_t;

	// Datapath -> controller status.
	typedef struct packed {
		op_t  op;
		logic used_h;
		logic used_i;
		logic hit;
		logic idx_last;
		logic cnt_last;
		logic stage_has;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/mcdt_dp.sv =====
// Datapath: slot flags, period/deadline memories, sweep index, staging and output register.
module mcdt_dp import mcdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  operation,
	input  logic [3:0]  handle,
	input  logic [31:0] interval,
	input  logic        periodic,
	input  logic [31:0] now_ms,
	input  ctl_cmd_t    ctl,
	output dp_stat_t    stat,
	input  logic        rsp_ready,
	output logic        rsp_valid,
	output logic [2:0]  kind,
	output logic        ok,
	output logic [3:0]  timer_index,
	output logic [31:0] time_left,
	output logic        last
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// latched request
	op_t         op_q;
	logic [3:0]  handle_q;
	logic [31:0] period_q;
	logic        reload_q;
	logic [31:0] now_q;

	logic [NUM_TIMERS-1:0] used_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [NUM_TIMERS-1:0] periodic_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] h_idx;
	logic          h_valid;
	logic          used_h;

	logic [31:0] per_mem [NUM_TIMERS];
	logic [31:0] dl_mem [NUM_TIMERS];
	logic [31:0] per_rd_q;
	logic [31:0] dl_rd_q;

	// staged result
	kind_t            st_kind_q;
	logic             st_ok_q;
	logic [3:0]       st_idx_q;
	logic [31:0]      st_rem_q;
	logic             st_has_q;
	logic [CNT_W-1:0] cnt_q;

	logic        out_valid_q;
	kind_t       out_kind_q;
	logic        out_ok_q;
	logic [3:0]  out_idx_q;
	logic [31:0] out_rem_q;
	logic        out_last_q;

	logic        active_i;
	logic        hit;
	logic [31:0] past_d;
	logic [31:0] ahead_d;
	logic [31:0] qrem;
	logic        push;
	logic        out_free;
	logic        ack_h;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			op_q     <= op_t'(operation);
			handle_q <= handle;
			period_q <= interval;
			reload_q <= periodic;
			now_q    <= now_ms;
		end
	end

	assign h_idx   = IW'(handle_q);
	assign h_valid = {28'd0, handle_q} < 32'(NUM_TIMERS);
	assign used_h  = h_valid && used_q[h_idx];

	always_comb begin
		if (ctl.rd_handle)
			rd_addr = h_idx;
		else if (ctl.idx_clr)
			rd_addr = '0;
		else if (ctl.idx_inc)
			rd_addr = idx_q + IW'(1);
		else
			rd_addr = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.idx_clr) begin
			idx_q <= '0;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// wrap-safe compares
	assign active_i = used_q[idx_q] && armed_q[idx_q];
	assign past_d   = now_q - dl_rd_q;
	assign hit      = active_i && !past_d[31];
	assign ahead_d  = dl_rd_q - now_q;
	assign qrem     = (ahead_d == 32'd0 || ahead_d[31]) ? 32'd0 : ahead_d;

	always_ff @(posedge clk) begin
		per_rd_q <= per_mem[rd_addr];
		dl_rd_q  <= dl_mem[rd_addr];
		if (ctl.create_claim)
			per_mem[idx_q] <= period_q;
		else if (ctl.do_set_period && used_h)
			per_mem[h_idx] <= period_q;
		if (ctl.do_start)
			dl_mem[h_idx] <= now_q + per_rd_q;
		else if (ctl.tick_hit && periodic_q[idx_q])
			dl_mem[idx_q] <= dl_rd_q + per_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			armed_q    <= '0;
			periodic_q <= '0;
		end else if (ctl.create_claim) begin
			used_q[idx_q]     <= 1'b1;
			armed_q[idx_q]    <= 1'b0;
			periodic_q[idx_q] <= reload_q;
		end else if (ctl.do_start) begin
			armed_q[h_idx] <= 1'b1;
		end else if (ctl.do_stop && used_h) begin
			armed_q[h_idx] <= 1'b0;
		end else if (ctl.do_delete && h_valid) begin
			used_q[h_idx]  <= 1'b0;
			armed_q[h_idx] <= 1'b0;
		end else if (ctl.tick_hit && !periodic_q[idx_q]) begin
			armed_q[idx_q] <= 1'b0;
		end
	end

	assign ack_h = (op_q == OP_START) || (op_q == OP_STOP) ||
		(op_q == OP_SET_PERIOD) || (op_q == OP_DELETE);

	always_ff @(posedge clk) begin
		if (ctl.stage_ack) begin
			st_kind_q <= KIND_ACK;
			st_ok_q   <= 1'b1;
			st_idx_q  <= ack_h ? handle_q : 4'd0;
			st_rem_q  <= '0;
		end else if (ctl.create_claim) begin
			st_kind_q <= KIND_CREATED;
			st_ok_q   <= 1'b1;
			st_idx_q  <= 4'(idx_q);
			st_rem_q  <= '0;
		end else if (ctl.create_fail) begin
			st_kind_q <= KIND_CREATED;
			st_ok_q   <= 1'b0;
			st_idx_q  <= 4'd0;
			st_rem_q  <= '0;
		end else if (ctl.tick_init) begin
			st_kind_q <= KIND_NONE;
			st_ok_q   <= 1'b1;
			st_idx_q  <= 4'd0;
			st_rem_q  <= '0;
		end else if (ctl.tick_hit) begin
			st_kind_q <= KIND_EXPIRED;
			st_ok_q   <= 1'b1;
			st_idx_q  <= 4'(idx_q);
			st_rem_q  <= '0;
		end else if (ctl.query_init) begin
			st_kind_q <= KIND_NEXT;
			st_ok_q   <= 1'b1;
			st_idx_q  <= 4'd0;
			st_rem_q  <= NONE_ARMED;
		end else if (ctl.query_step && active_i && qrem < st_rem_q) begin
			st_rem_q <= qrem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_has_q <= 1'b0;
			cnt_q    <= '0;
		end else if (ctl.tick_init) begin
			st_has_q <= 1'b0;
			cnt_q    <= '0;
		end else if (ctl.tick_hit) begin
			st_has_q <= 1'b1;
			cnt_q    <= cnt_q + CNT_W'(1);
		end
	end

	// a new expiry pushes the one held before it; the final result goes with last
	assign push     = ctl.push_last || (ctl.tick_hit && st_has_q);
	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q <= st_kind_q;
			out_ok_q   <= st_ok_q;
			out_idx_q  <= st_idx_q;
			out_rem_q  <= st_rem_q;
			out_last_q <= ctl.push_last;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign ok          = out_ok_q;
	assign timer_index = out_idx_q;
	assign time_left   = out_rem_q;
	assign last        = out_last_q;

	assign stat.op        = op_q;
	assign stat.used_h    = used_h;
	assign stat.used_i    = used_q[idx_q];
	assign stat.hit       = hit;
	assign stat.idx_last  = (idx_q == IW'(NUM_TIMERS - 1));
	assign stat.cnt_last  = (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign stat.stage_has = st_has_q;
	assign stat.out_free  = out_free;

	a_armed_used: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~used_q) == '0)
		else $error("armed slot not in use");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over an untaken result");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("tick reported too many expiries");

	a_hit_real: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tick_hit |-> hit)
		else $error("expiry committed for a slot that has not expired");

endmodule

// ===== src/mcdt_ctrl.sv =====
// Controller state machine: sequences each request over the datapath.
module mcdt_ctrl import mcdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	state_t state_q;
	state_t state_nx;
	logic   tick_stall;

	// an expiry waits while the held one cannot be handed on
	assign tick_stall = stat.hit && stat.stage_has && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid)
					state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (stat.op)
					OP_CREATE: state_nx = ST_CREATE;
					OP_START:  state_nx = stat.used_h ? ST_START_WR : ST_RESP;
					OP_TICK:   state_nx = ST_TICK;
					OP_QUERY:  state_nx = ST_QUERY;
					default:   state_nx = ST_RESP;
				endcase
			end
			ST_START_WR: state_nx = ST_RESP;
			ST_CREATE: begin
				if (!stat.used_i || stat.idx_last)
					state_nx = ST_RESP;
			end
			ST_TICK: begin
				if (stat.hit) begin
					if (!tick_stall && (stat.idx_last || stat.cnt_last))
						state_nx = ST_RESP;
				end else if (stat.idx_last) begin
					state_nx = ST_RESP;
				end
			end
			ST_QUERY: begin
				if (stat.idx_last)
					state_nx = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				ctl.load_in = req_valid;
			end
			ST_DISPATCH: begin
				unique case (stat.op)
					OP_CREATE: ctl.idx_clr = 1'b1;
					OP_START: begin
						ctl.stage_ack = 1'b1;
						ctl.rd_handle = stat.used_h;
					end
					OP_STOP: begin
						ctl.stage_ack = 1'b1;
						ctl.do_stop   = 1'b1;
					end
					OP_SET_PERIOD: begin
						ctl.stage_ack     = 1'b1;
						ctl.do_set_period = 1'b1;
					end
					OP_DELETE: begin
						ctl.stage_ack = 1'b1;
						ctl.do_delete = 1'b1;
					end
					OP_TICK: begin
						ctl.idx_clr   = 1'b1;
						ctl.tick_init = 1'b1;
					end
					OP_QUERY: begin
						ctl.idx_clr    = 1'b1;
						ctl.query_init = 1'b1;
					end
					default: ctl.stage_ack = 1'b1;
				endcase
			end
			ST_START_WR: ctl.do_start = 1'b1;
			ST_CREATE: begin
				if (!stat.used_i)
					ctl.create_claim = 1'b1;
				else if (stat.idx_last)
					ctl.create_fail = 1'b1;
				else
					ctl.idx_inc = 1'b1;
			end
			ST_TICK: begin
				if (stat.hit) begin
					if (!tick_stall) begin
						ctl.tick_hit = 1'b1;
						ctl.idx_inc  = !(stat.idx_last || stat.cnt_last);
					end
				end else begin
					ctl.idx_inc = !stat.idx_last;
				end
			end
			ST_QUERY: begin
				ctl.query_step = 1'b1;
				ctl.idx_inc    = !stat.idx_last;
			end
			ST_RESP: ctl.push_last = stat.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

// ===== src/multi_channel_deadline_timer.sv =====
// Top level of the multi-channel deadline timer table.
// A table of NUM_TIMERS timer slots, one request at a time. Create claims the
// lowest free slot (kind created, ok 0 when the table is full); start arms a
// slot with deadline now_ms + period; stop, set period and delete act on the
// slot named by handle and answer with one acknowledge. A service tick sweeps
// the slots in ascending order and returns one expired result per slot whose
// deadline has been reached (wrap-safe, signed difference), at most
// MAX_RESULTS per tick, or one nothing-expired result; periodic slots move
// their deadline on by one period, one-shot slots disarm. Query returns the
// least remaining time over armed slots, clamped at zero, or all ones.
// The final result of every request has last set.
// Timing: the request port takes one request and is busy until its final
// result sits in the output register; the output register lets the next
// request in while that result still waits to be taken. Start reads the
// period memory before it writes the deadline. Create walks the slots from
// index 0 up to the first free one, or through all of them when the table is
// full; tick and query sweep the slots, one slot per cycle except where a
// tick holds, through the registered read port of the deadline and period
// memories. A tick holds at an expiry, and every request holds in its final
// cycle, for as long as the output register keeps a result that has not
// been taken.
module multi_channel_deadline_timer import mcdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  operation,
	input  logic [3:0]  handle,
	input  logic [31:0] interval,
	input  logic        periodic,
	input  logic [31:0] now_ms,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  kind,
	output logic        ok,
	output logic [3:0]  timer_index,
	output logic [31:0] time_left,
	output logic        last
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// sequencing only; every stored value lives in the datapath
	mcdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	mcdt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.handle      (handle),
		.interval    (interval),
		.periodic    (periodic),
		.now_ms      (now_ms),
		.ctl         (ctl),
		.stat        (stat),
		.rsp_ready   (rsp_ready),
		.rsp_valid   (rsp_valid),
		.kind        (kind),
		.ok          (ok),
		.timer_index (timer_index),
		.time_left   (time_left),
		.last        (last)
	);

endmodule
